// ----- design/bmhpq_pkg.sv -----
// shared types and codes for the binary min-heap priority queue
// no dependencies; used by the top level and its checker
package bmhpq_pkg;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned PRIO_W  = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    cmd_t                     command;
    logic signed [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]         tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]         out_tag;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
  } entry_t;

  localparam int unsigned ENTRY_W = PRIO_W + TAG_W;

endpackage

// ----- design/bmhpq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bmhpq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/binary_min_heap_priority_queue.sv -----
// binary min-heap priority queue, one command in flight at a time; depends on bmhpq_pkg, bmhpq_ram
// clear and any error go straight to the result register; peek reads the root; enqueue
// climbs from the new last slot while its parent is greater; dequeue reads the root and the
// last entry, then, unless that was the only entry, sinks it from the root towards its smaller
// child; a new command is taken only once the last result is in the output register
// reset (rst_n low, synchronous) empties the queue; the ram is not cleared, as entries at or
// beyond the count are never read
module binary_min_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bmhpq_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bmhpq_pkg::out_item_t out_item
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // wide enough for the right child index of the last slot
  localparam int unsigned EW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,       // hole at pos_r: finish at root or fetch parent
    S_UP_CMP,   // parent data back: move parent down or drop entry in
    S_DQ_ROOT,  // root data back: keep it, fetch last entry
    S_DQ_LAST,  // last entry back: it becomes the moving entry
    S_DN,       // hole at pos_r: finish at a leaf or fetch left child
    S_DN_L,     // left child back: fetch right child if there is one
    S_DN_R,     // right child back: pick the smaller child
    S_PEEK,     // root data back
    S_FIN       // hand the result to the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  bmhpq_pkg::entry_t    mov_r, mov_nxt;      // entry being sifted
  bmhpq_pkg::entry_t    left_r, left_nxt;    // left child during sift down
  bmhpq_pkg::entry_t    root_r, root_nxt;    // entry reported in the result
  logic [1:0]           status_r, status_nxt;
  bmhpq_pkg::out_item_t out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // ram controls
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  bmhpq_pkg::entry_t     ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [bmhpq_pkg::ENTRY_W-1:0] ram_rdata;
  bmhpq_pkg::entry_t     rd_entry;

  // child and parent indices
  logic [EW-1:0]         lchild_ext, rchild_ext, cnt_ext;
  logic [AW-1:0]         parent_addr;
  logic                  right_wins;
  bmhpq_pkg::entry_t     cand;
  logic [AW-1:0]         cand_addr;

  assign rd_entry    = bmhpq_pkg::entry_t'(ram_rdata);
  assign lchild_ext  = {1'b0, pos_r, 1'b1};
  assign rchild_ext  = lchild_ext + EW'(1);
  assign cnt_ext     = EW'(cnt_r);
  assign parent_addr = AW'((pos_r - AW'(1)) >> 1);
  // strict compare, so the left child wins ties
  assign right_wins  = rd_entry.prio < left_r.prio;

  always_comb begin
    cand      = rd_entry;
    cand_addr = lchild_ext[AW-1:0];
    if (state_r == S_DN_R) begin
      if (right_wins) begin
        cand_addr = rchild_ext[AW-1:0];
      end else begin
        cand      = left_r;
      end
    end
  end

  bmhpq_ram #(
    .WIDTH(bmhpq_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    mov_nxt       = mov_r;
    left_nxt      = left_r;
    root_nxt      = root_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = mov_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          root_nxt   = '0;
          status_nxt = bmhpq_pkg::ST_OK;
          state_nxt  = S_FIN;
          case (in_item.command)
            bmhpq_pkg::CMD_ENQUEUE: begin
              if (cnt_r == CW'(CAPACITY)) begin
                status_nxt = bmhpq_pkg::ST_FULL;
              end else begin
                mov_nxt.prio = in_item.priority_req;
                mov_nxt.tag  = in_item.tag;
                pos_nxt      = AW'(cnt_r);
                cnt_nxt      = cnt_r + CW'(1);
                state_nxt    = S_UP;
              end
            end
            bmhpq_pkg::CMD_DEQUEUE, bmhpq_pkg::CMD_PEEK: begin
              if (cnt_r == '0) begin
                status_nxt = bmhpq_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                state_nxt = (in_item.command == bmhpq_pkg::CMD_PEEK) ? S_PEEK : S_DQ_ROOT;
              end
            end
            default: begin
              cnt_nxt = '0;
            end
          endcase
        end
      end

      S_UP: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_addr;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (mov_r.prio < rd_entry.prio) begin
          ram_wdata = rd_entry;
          pos_nxt   = parent_addr;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_DQ_ROOT: begin
        root_nxt  = rd_entry;
        ram_re    = 1'b1;
        ram_raddr = AW'(cnt_r - CW'(1));
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_DQ_LAST;
      end

      S_DQ_LAST: begin
        mov_nxt   = rd_entry;
        pos_nxt   = '0;
        state_nxt = (cnt_r == '0) ? S_FIN : S_DN;
      end

      S_DN: begin
        if (lchild_ext >= cnt_ext) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = lchild_ext[AW-1:0];
          state_nxt = S_DN_L;
        end
      end

      S_DN_L, S_DN_R: begin
        if (state_r == S_DN_L && rchild_ext < cnt_ext) begin
          left_nxt  = rd_entry;
          ram_re    = 1'b1;
          ram_raddr = rchild_ext[AW-1:0];
          state_nxt = S_DN_R;
        end else begin
          ram_we = 1'b1;
          if (cand.prio < mov_r.prio) begin
            ram_wdata = cand;
            pos_nxt   = cand_addr;
            state_nxt = S_DN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_PEEK: begin
        root_nxt  = rd_entry;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status       = status_r;
          out_nxt.out_priority = root_r.prio;
          out_nxt.out_tag      = root_r.tag;
          out_nxt.count        = bmhpq_pkg::COUNT_W'(cnt_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r    <= pos_nxt;
    mov_r    <= mov_nxt;
    left_r   <= left_nxt;
    root_r   <= root_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  // one command at a time; the output register lets a result wait while idle
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- design/bmhpq_checker.sv -----
// port-level checks for the binary min-heap priority queue, bound to the top level
// depends on bmhpq_pkg
module bmhpq_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input bmhpq_pkg::out_item_t out_item
);

  localparam logic [bmhpq_pkg::COUNT_W-1:0] CAP_COUNT = bmhpq_pkg::COUNT_W'(CAPACITY);

  // one command in flight: the input closes right after an item is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // error results carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != bmhpq_pkg::ST_OK |->
      out_item.out_priority == '0 && out_item.out_tag == '0)
    else $error("error result carries an entry");

  // empty error only with nothing held, full error only at capacity
  a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_item.status != bmhpq_pkg::ST_EMPTY || out_item.count == '0) &&
      (out_item.status != bmhpq_pkg::ST_FULL || out_item.count == CAP_COUNT))
    else $error("error status disagrees with count");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status == bmhpq_pkg::ST_OK ||
      out_item.status == bmhpq_pkg::ST_EMPTY || out_item.status == bmhpq_pkg::ST_FULL)
    else $error("bad status code");

endmodule

bind binary_min_heap_priority_queue bmhpq_checker #(.CAPACITY(CAPACITY)) u_bmhpq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

// ----- tb/binary_min_heap_priority_queue_tb.sv -----
// self-checking testbench for the binary min-heap priority queue: a scoreboard class
// keeps its own heap and checks every result item; plain tasks drive the input channel
// and a receiver process drives out_ready; depends on bmhpq_pkg and the binary_min_heap_priority_queue top level
module binary_min_heap_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // wait after draining, longer than the longest command, so a late stray item is caught
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 135;
  localparam int unsigned HOLD_CYCLES = 300;

  // heap predictor plus the queue of result items still owed by the block
  class heap_scoreboard;
    bmhpq_pkg::entry_t    slots [DEPTH];
    int unsigned          held;
    bmhpq_pkg::out_item_t awaited [$];
    int unsigned          errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // smaller priority is served first, compared as signed
    function bit served_first(bmhpq_pkg::entry_t a, bmhpq_pkg::entry_t b);
      return $signed(a.prio) < $signed(b.prio);
    endfunction

    function void swap_slots(int unsigned i, int unsigned j);
      bmhpq_pkg::entry_t t;
      t        = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    endfunction

    // new entry climbs while its parent is strictly greater
    function void climb(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (!served_first(slots[pos], slots[parent])) break;
        swap_slots(pos, parent);
        pos = parent;
      end
    endfunction

    // root sinks towards its smaller child, left child on a tie
    function void sink();
      int unsigned pos;
      int unsigned lc;
      int unsigned pick;
      pos = 0;
      forever begin
        lc = 2 * pos + 1;
        if (lc >= held) break;
        pick = lc;
        if (lc + 1 < held && served_first(slots[lc + 1], slots[lc])) pick = lc + 1;
        if (!served_first(slots[pick], slots[pos])) break;
        swap_slots(pos, pick);
        pos = pick;
      end
    endfunction

    function void note_command(bmhpq_pkg::in_item_t it);
      bmhpq_pkg::out_item_t res;
      bmhpq_pkg::entry_t    root;
      res  = '0;
      root = '0;
      case (it.command)
        bmhpq_pkg::CMD_ENQUEUE: begin
          if (held >= DEPTH) begin
            res.status = bmhpq_pkg::ST_FULL;
          end else begin
            slots[held].prio = it.priority_req;
            slots[held].tag  = it.tag;
            held++;
            climb(held - 1);
          end
        end
        bmhpq_pkg::CMD_DEQUEUE: begin
          if (held == 0) begin
            res.status = bmhpq_pkg::ST_EMPTY;
          end else begin
            root     = slots[0];
            slots[0] = slots[held - 1];
            held--;
            sink();
          end
        end
        bmhpq_pkg::CMD_PEEK: begin
          if (held == 0) res.status = bmhpq_pkg::ST_EMPTY;
          else root = slots[0];
        end
        default: begin
          held = 0;
        end
      endcase
      res.out_priority = root.prio;
      res.out_tag      = root.tag;
      res.count        = bmhpq_pkg::COUNT_W'(held);
      awaited.push_back(res);
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task check_result(bmhpq_pkg::out_item_t got);
      bmhpq_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        report("item with nothing awaited", '0, 64'(got));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report("status", 64'(want.status), 64'(got.status));
      if (got.out_priority !== want.out_priority)
        report("out_priority", 64'(want.out_priority), 64'(got.out_priority));
      if (got.out_tag !== want.out_tag)
        report("out_tag", 64'(want.out_tag), 64'(got.out_tag));
      if (got.count !== want.count)
        report("count", 64'(want.count), 64'(got.count));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  bmhpq_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  bmhpq_pkg::out_item_t out_item;

  heap_scoreboard sb = new();

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // raised by the stimulus, taken up by the receiver process
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned sent;
  int unsigned cycles        = 0;

  binary_min_heap_priority_queue #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result items are checked at the rising edge they are taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // receiver: random back-pressure, or a long hold when asked for one
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one item, with random idle cycles in front, and wait until it is taken
  task automatic send_item(bmhpq_pkg::cmd_t c, logic [31:0] p, logic [15:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid              = 1'b1;
    in_item.command       = c;
    in_item.priority_req  = p;
    in_item.tag           = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // acceptance is noted here so the model state is current for the next choice
    sb.note_command(in_item);
    sent++;
  endtask

  // sender stops and waits for every owed result item
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // priorities: extremes, a narrow band around zero for ties, or anything at all
  function automatic logic [31:0] pick_prio();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2, 3, 4: v = 32'($urandom_range(0, 7)) - 32'd4;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_mixed();
    int unsigned     r;
    bmhpq_pkg::cmd_t c;
    r = $urandom_range(0, 99);
    if (r < 47)      c = bmhpq_pkg::CMD_ENQUEUE;
    else if (r < 77) c = bmhpq_pkg::CMD_DEQUEUE;
    else if (r < 96) c = bmhpq_pkg::CMD_PEEK;
    else             c = bmhpq_pkg::CMD_CLEAR;
    send_item(c, pick_prio(), 16'($urandom_range(0, 65535)));
  endtask

  // fill the heap to the brim and past it, then empty it and ask once more
  task automatic fill_and_drain();
    while (sb.held < DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        send_item(bmhpq_pkg::CMD_PEEK, pick_prio(), 16'($urandom()));
      send_item(bmhpq_pkg::CMD_ENQUEUE, pick_prio(), 16'($urandom()));
    end
    send_item(bmhpq_pkg::CMD_ENQUEUE, pick_prio(), 16'($urandom()));
    send_item(bmhpq_pkg::CMD_PEEK, pick_prio(), 16'($urandom()));
    send_item(bmhpq_pkg::CMD_ENQUEUE, pick_prio(), 16'($urandom()));
    while (sb.held > 0) send_item(bmhpq_pkg::CMD_DEQUEUE, pick_prio(), 16'($urandom()));
    send_item(bmhpq_pkg::CMD_DEQUEUE, pick_prio(), 16'($urandom()));
  endtask

  task automatic run_phase(int unsigned s_pct, int unsigned r_pct, bit long_hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent          = 0;
    repeat (10) send_mixed();
    // receiver holds off while the fill keeps coming, so the input stalls
    if (long_hold) hold_req = 1'b1;
    fill_and_drain();
    while (sent < PHASE_ITEMS) send_mixed();
    wait_drained();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty errors, extremes, ties, last entry out, clear
    send_item(bmhpq_pkg::CMD_PEEK,    32'h0000_0000, 16'h0000);
    send_item(bmhpq_pkg::CMD_DEQUEUE, 32'hffff_ffff, 16'hffff);
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'h7fff_ffff, 16'hffff);
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'h8000_0000, 16'h0000);
    send_item(bmhpq_pkg::CMD_PEEK,    32'h1234_5678, 16'h9abc);
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'h0000_0000, 16'h1234);
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'hffff_ffff, 16'haaaa);
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'h0001_0000, 16'h5555);
    // equal priorities: the left child must win
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'h0001_0000, 16'h2222);
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'h0001_0000, 16'h3333);
    repeat (5) send_item(bmhpq_pkg::CMD_DEQUEUE, 32'h0, 16'h0);
    send_item(bmhpq_pkg::CMD_PEEK,    32'h0, 16'h0);
    send_item(bmhpq_pkg::CMD_CLEAR,   32'hdead_beef, 16'hbeef);
    send_item(bmhpq_pkg::CMD_PEEK,    32'h0, 16'h0);
    send_item(bmhpq_pkg::CMD_DEQUEUE, 32'h0, 16'h0);
    send_item(bmhpq_pkg::CMD_ENQUEUE, 32'h0000_0005, 16'h0001);
    // dequeue of the only entry leaves the heap empty
    send_item(bmhpq_pkg::CMD_DEQUEUE, 32'h0, 16'h0);
    send_item(bmhpq_pkg::CMD_DEQUEUE, 32'h0, 16'h0);
    wait_drained();

    run_phase(9, 84, 1'b0);
    run_phase(84, 9, 1'b0);
    run_phase(0, 0, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) sb.report("items never returned", '0, 64'(sb.outstanding()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- binary_min_heap_priority_queue.f -----
design/bmhpq_pkg.sv
design/bmhpq_ram.sv
design/binary_min_heap_priority_queue.sv
design/bmhpq_checker.sv
tb/binary_min_heap_priority_queue_tb.sv
